>>> rtl/rcfd_pkg.sv
package rcfd_pkg;

  localparam int unsigned FRAME_LEN = 18;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CHAN_W    = 11;
  localparam int unsigned SW_W      = 2;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX       = 5'd31;
  localparam logic [CNT_W-1:0]  LAST_POS      = 5'(FRAME_LEN - 1);
  localparam logic [CHAN_W-1:0] MIN_RESET     = 11'd364;
  localparam logic [CHAN_W-1:0] MAX_RESET     = 11'd1684;
  localparam logic [CHAN_W-1:0] CENTER_RESET  = 11'd1024;
  localparam logic [SW_W-1:0]   SW_INVALID    = 2'd0;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MIN    = 2'd0;
  localparam logic [1:0] REG_MAX    = 2'd1;
  localparam logic [1:0] REG_CENTER = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_LEN = 2'd1,
    STAT_SW  = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;
    logic [CHAN_W-1:0] chan4;
    logic [SW_W-1:0]   switch_a;
    logic [SW_W-1:0]   switch_b;
    logic [1:0]        frame_status;
  } out_item_t;

endpackage

>>> rtl/rc_receiver_frame_decode.sv
// An accepted frame-end byte loads its result into the output register, or into
//   the skid register while the output is stalled. Other bytes give no result.
// Throughput: one byte per cycle unless stalled; the output and one skid register
//   keep the input open while a result waits; in_stall rises only with both full.
// Reset (rst_n low, synchronous): byte count and valid flags clear, limits return
//   to 364/1684, held channels to 1024 and held switches to 0. No clearing pass.
module rc_receiver_frame_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rcfd_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rcfd_pkg::out_item_t       out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rcfd_pkg::ADDR_W-1:0] paddr,
  input  logic [rcfd_pkg::DATA_W-1:0] pwdata,
  output logic [rcfd_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import rcfd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0] chan_min_r;
  logic [CHAN_W-1:0] chan_max_r;
  logic [CHAN_W-1:0] chan_center_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_min_r    <= MIN_RESET;
      chan_max_r    <= MAX_RESET;
      chan_center_r <= CENTER_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN:    chan_min_r    <= pwdata[CHAN_W-1:0];
        REG_MAX:    chan_max_r    <= pwdata[CHAN_W-1:0];
        REG_CENTER: chan_center_r <= pwdata[CHAN_W-1:0];
        default: ;  // no register here: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN:    prdata = DATA_W'(chan_min_r);
      REG_MAX:    prdata = DATA_W'(chan_max_r);
      REG_CENTER: prdata = DATA_W'(chan_center_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register with one skid register behind it. The input
  // only stalls when the skid holds a result, which implies the output is full.
  // ---------------------------------------------------------------------------
  logic      in_acc;
  logic      out_free;
  logic      produce;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r;
  out_item_t skid_data_r;
  out_item_t result;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign produce   = in_acc && in_data.frame_end;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Frame store and byte count
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]       frame_r [FRAME_LEN];

  always_comb begin
    if (in_data.frame_end) begin
      byte_cnt_nxt = '0;
    end else if (byte_cnt_r == CNT_MAX) begin
      byte_cnt_nxt = byte_cnt_r;  // saturate on over-long frames
    end else begin
      byte_cnt_nxt = byte_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
    end else if (in_acc) begin
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  // Bytes beyond the frame length are dropped; no reset on the payload store.
  always_ff @(posedge clk) begin
    if (in_acc && (byte_cnt_r < CNT_W'(FRAME_LEN))) begin
      frame_r[byte_cnt_r] <= in_data.rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode. The last byte of a good frame is the one on the input now, so
  // byte 17 is taken from the input rather than the store.
  // ---------------------------------------------------------------------------
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v,
                                                   input logic [CHAN_W-1:0] lo,
                                                   input logic [CHAN_W-1:0] hi);
    logic [CHAN_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [7:0]        last_byte;
  logic [SW_W-1:0]   sw_a, sw_b;
  logic              len_ok, sw_ok, frame_ok;
  logic [CHAN_W-1:0] raw [5];
  logic [CHAN_W-1:0] held_r [5];
  logic [CHAN_W-1:0] held_nxt [5];
  logic [SW_W-1:0]   sw_a_r, sw_a_nxt;
  logic [SW_W-1:0]   sw_b_r, sw_b_nxt;
  frame_status_t     status;

  assign last_byte = in_data.rx_byte;
  assign sw_a      = frame_r[5][7:6];
  assign sw_b      = frame_r[5][5:4];
  assign len_ok    = (byte_cnt_r == LAST_POS);
  assign sw_ok     = (sw_a != SW_INVALID) && (sw_b != SW_INVALID);
  assign frame_ok  = len_ok && sw_ok;

  // Unpack the 11-bit little-endian bit fields.
  assign raw[0] = {frame_r[1][2:0], frame_r[0]};
  assign raw[1] = {frame_r[2][5:0], frame_r[1][7:3]};
  assign raw[2] = {frame_r[4][0],   frame_r[3], frame_r[2][7:6]};
  assign raw[3] = {frame_r[5][3:0], frame_r[4][7:1]};
  assign raw[4] = {last_byte[2:0],  frame_r[16]};

  always_comb begin
    // Length error takes precedence over a bad switch code.
    if (!len_ok) begin
      status = STAT_LEN;
    end else if (!sw_ok) begin
      status = STAT_SW;
    end else begin
      status = STAT_OK;
    end
  end

  // Replace held values only on a good frame; otherwise hold them.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      held_nxt[i] = frame_ok ? clamp_chan(raw[i], chan_min_r, chan_max_r) : held_r[i];
    end
    sw_a_nxt = frame_ok ? sw_a : sw_a_r;
    sw_b_nxt = frame_ok ? sw_b : sw_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        held_r[i] <= CENTER_RESET;
      end
      sw_a_r <= '0;
      sw_b_r <= '0;
    end else if (produce) begin
      for (int i = 0; i < 5; i++) begin
        held_r[i] <= held_nxt[i];
      end
      sw_a_r <= sw_a_nxt;
      sw_b_r <= sw_b_nxt;
    end
  end

  always_comb begin
    result.chan0        = held_nxt[0];
    result.chan1        = held_nxt[1];
    result.chan2        = held_nxt[2];
    result.chan3        = held_nxt[3];
    result.chan4        = held_nxt[4];
    result.switch_a     = sw_a_nxt;
    result.switch_b     = sw_b_nxt;
    result.frame_status = status;
  end

  // ---------------------------------------------------------------------------
  // Result register and skid
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      // Output empties or stays empty: refill from the skid first, else new.
      out_valid_nxt  = skid_valid_r || produce;
      skid_valid_nxt = 1'b0;
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (produce) begin
        out_data_r <= result;
      end
    end else if (produce) begin
      skid_data_r <= result;
    end
  end

endmodule

>>> rtl/rcfd_checker.sv
module rcfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rcfd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rcfd_pkg::out_item_t out_data
);
  import rcfd_pkg::*;

  // A stalled result holds its place and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The input only stalls behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A fresh result follows an accepted frame-end byte.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.frame_end))
    else $error("result without a frame end");

  // An accepted frame always carries valid switch codes.
  a_ok_switches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_status == STAT_OK) |->
      (out_data.switch_a != SW_INVALID) && (out_data.switch_b != SW_INVALID))
    else $error("accepted frame with an invalid switch code");

endmodule

bind rc_receiver_frame_decode rcfd_checker u_rcfd_checker (.*);

>>> sim/tb_rc_receiver_frame_decode.sv
module tb_rc_receiver_frame_decode;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfd_pkg::*;

  // Register slot that decodes to nothing; writes there must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Top of the 11-bit channel range and of the 2-bit switch range.
  localparam logic [CHAN_W-1:0] CHAN_TOP = 11'd2047;
  localparam logic [SW_W-1:0]   SW_TOP   = 2'd3;

  // How byte 5 (the switch byte) of a generated frame is shaped.
  typedef enum logic [1:0] {
    SW_RAW,       // leave the random byte as it is
    SW_BOTH_SET,  // force both switch codes nonzero
    SW_A_CLEAR,   // force switch A to the invalid code
    SW_B_CLEAR    // force switch B to the invalid code
  } frame_sw_t;

  // One row of the directed table: the request, and optionally a
  // hand-written report that replaces the predicted one.
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  localparam out_item_t NO_REPORT = '0;
  // Short frame straight after reset: centre values, zero switches.
  localparam out_item_t RESET_LEN_ERR =
    {{5{CENTER_RESET}}, 2'd0, 2'd0, STAT_LEN};
  // All-ones frame under reset limits: every channel clamps to the maximum.
  localparam out_item_t ONES_OK = {{5{MAX_RESET}}, SW_TOP, SW_TOP, STAT_OK};
  // A later short frame keeps what the all-ones frame left behind.
  localparam out_item_t ONES_LEN_ERR = {{5{MAX_RESET}}, SW_TOP, SW_TOP, STAT_LEN};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Idling knobs, in percent per cycle.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Long receiver hold-off, counted down by the stall process.
  int unsigned hold_cycles    = 0;

  int unsigned mismatch_count = 0;

  // Reports still owed by the block, oldest first.
  out_item_t frame_reports [$];

  // Mirror of the decoder state.
  logic [CNT_W-1:0]  rx_count = '0;
  logic [7:0]        frame_buf [FRAME_LEN];
  logic [CHAN_W-1:0] held_chan [5];
  logic [SW_W-1:0]   held_sw_a = '0;
  logic [SW_W-1:0]   held_sw_b = '0;
  logic [CHAN_W-1:0] lo_limit   = MIN_RESET;
  logic [CHAN_W-1:0] hi_limit   = MAX_RESET;
  logic [CHAN_W-1:0] center_val = CENTER_RESET;

  // Directed opening: a one-byte frame straight after reset, an all-ones
  // frame of the right length (channels at the top, switches at the top),
  // then a two-byte frame that must leave the held values alone.
  stim_row_t directed_tbl [21] = '{
    {8'h00, 1'b1, 1'b1, RESET_LEN_ERR},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b0, 1'b0, NO_REPORT},
    {8'hFF, 1'b1, 1'b1, ONES_OK},
    {8'h00, 1'b0, 1'b0, NO_REPORT},
    {8'h00, 1'b1, 1'b1, ONES_LEN_ERR}
  };

  rc_receiver_frame_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out the report (if any) that one received byte causes, and
  // advance the mirrored state. Returns 1 when the byte closes a frame.
  function automatic bit decode_rx_byte(input in_item_t req, output out_item_t rep);
    logic [CNT_W-1:0]  pos;
    logic [SW_W-1:0]   sw_a;
    logic [SW_W-1:0]   sw_b;
    logic [CHAN_W-1:0] raw [5];
    pos = rx_count;
    rep = '0;
    // Store only the first eighteen positions; the count sticks at its top.
    if (pos < FRAME_LEN) frame_buf[pos] = req.rx_byte;
    if (rx_count != CNT_MAX) rx_count++;
    if (!req.frame_end) return 1'b0;
    rx_count = '0;
    sw_a = frame_buf[5][7:6];
    sw_b = frame_buf[5][5:4];
    // Length is judged first, so a short frame with bad switches is a
    // length error; the switch byte is only trusted in a full frame.
    if (pos != LAST_POS) begin
      rep.frame_status = STAT_LEN;
    end else if (sw_a == SW_INVALID || sw_b == SW_INVALID) begin
      rep.frame_status = STAT_SW;
    end else begin
      raw[0] = 11'({frame_buf[1], frame_buf[0]});
      raw[1] = 11'({frame_buf[2], frame_buf[1]} >> 3);
      raw[2] = 11'({frame_buf[4], frame_buf[3], frame_buf[2]} >> 6);
      raw[3] = 11'({frame_buf[5], frame_buf[4]} >> 1);
      raw[4] = 11'({frame_buf[17], frame_buf[16]});
      // When the limits cross, values below the lower limit take it; all others take the upper.
      for (int i = 0; i < 5; i++) begin
        if (raw[i] < lo_limit) held_chan[i] = lo_limit;
        else if (raw[i] > hi_limit) held_chan[i] = hi_limit;
        else held_chan[i] = raw[i];
      end
      held_sw_a = sw_a;
      held_sw_b = sw_b;
      rep.frame_status = STAT_OK;
    end
    rep.chan0    = held_chan[0];
    rep.chan1    = held_chan[1];
    rep.chan2    = held_chan[2];
    rep.chan3    = held_chan[3];
    rep.chan4    = held_chan[4];
    rep.switch_a = held_sw_a;
    rep.switch_b = held_sw_b;
    return 1'b1;
  endfunction

  // Offer one byte request, hold it until accepted, then record the report
  // it owes. Called and returns just after a rising edge.
  task automatic offer_byte(input in_item_t req, input logic typed, input out_item_t want);
    out_item_t rep;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (decode_rx_byte(req, rep)) frame_reports.push_back(typed ? want : rep);
  endtask

  // Send one frame of the given length; frame_end rides on the last byte.
  // A negative fill gives random bytes.
  task automatic send_frame(input int len, input frame_sw_t mode, input int fill);
    logic [7:0] b;
    int         i;
    for (i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 5) begin
        case (mode)
          SW_BOTH_SET: begin
            b[7:6] = 2'($urandom_range(1, 3));
            b[5:4] = 2'($urandom_range(1, 3));
          end
          SW_A_CLEAR: b[7:6] = SW_INVALID;
          SW_B_CLEAR: b[5:4] = SW_INVALID;
          default: ;
        endcase
      end
      offer_byte({b, 1'(i == len - 1)}, 1'b0, NO_REPORT);
    end
  endtask

  // Well-formed frames with random content, mixed with short (short_pct percent), long,
  // bad-switch or untouched switch bytes.
  task automatic send_random_frames(input int byte_budget, input int short_pct);
    int        sent;
    int        frames;
    int        pick;
    int        len;
    frame_sw_t mode;
    sent   = 0;
    frames = 0;
    while (sent < byte_budget || frames < 3) begin
      pick = $urandom_range(99);
      len  = FRAME_LEN;
      mode = SW_BOTH_SET;
      if (pick < short_pct) begin
        len  = $urandom_range(1, FRAME_LEN - 1);
        mode = frame_sw_t'($urandom_range(3));
      end else if (pick < short_pct + 8) begin
        mode = $urandom_range(1) ? SW_A_CLEAR : SW_B_CLEAR;
      end else if (pick < short_pct + 14) begin
        len = $urandom_range(FRAME_LEN + 1, 40);
      end else if (pick < short_pct + 17) begin
        len = $urandom_range(41, 64);
      end else if (pick < short_pct + 20) begin
        mode = SW_RAW;
      end
      send_frame(len, mode, -1);
      sent   += len;
      frames++;
    end
  endtask

  // Setup then access phase; the register takes the value on the access edge.
  task automatic write_limit_reg(input logic [1:0] idx, input logic [CHAN_W-1:0] val);
    logic [DATA_W-1:0] noise;
    noise = $urandom;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Upper bits are junk: only the low eleven should land.
    pwdata  <= {noise[DATA_W-1:CHAN_W], val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN:    lo_limit   = val;
      REG_MAX:    hi_limit   = val;
      REG_CENTER: center_val = val;
      default: ;
    endcase
  endtask

  // Drop valid, wait for every owed report, then allow the block to settle.
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input out_item_t want,
                               input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: exp ch %0d %0d %0d %0d %0d sw %0d %0d st %0d",
               $realtime, what, want.chan0, want.chan1, want.chan2, want.chan3,
               want.chan4, want.switch_a, want.switch_b, want.frame_status,
               "  got ch %0d %0d %0d %0d %0d sw %0d %0d st %0d",
               got.chan0, got.chan1, got.chan2, got.chan3, got.chan4,
               got.switch_a, got.switch_b, got.frame_status);
  endtask

  // Receiver: random stalls, or a solid hold-off while hold_cycles runs down.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Report checker: every accepted report must match the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (frame_reports.size() == 0) begin
        note_mismatch("report with nothing owed", NO_REPORT, out_data);
      end else begin
        want = frame_reports.pop_front();
        if (out_data.chan0 !== want.chan0 || out_data.chan1 !== want.chan1 ||
            out_data.chan2 !== want.chan2 || out_data.chan3 !== want.chan3 ||
            out_data.chan4 !== want.chan4 ||
            out_data.switch_a !== want.switch_a ||
            out_data.switch_b !== want.switch_b ||
            out_data.frame_status !== want.frame_status)
          note_mismatch("report differs", want, out_data);
      end
    end
  end

  initial begin
    foreach (held_chan[i]) held_chan[i] = CENTER_RESET;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limits, no idling: directed table, then the awkward frames.
    foreach (directed_tbl[i])
      offer_byte(directed_tbl[i].req, directed_tbl[i].typed, directed_tbl[i].want);
    send_frame(FRAME_LEN, SW_BOTH_SET, 0);      // all channels zero: clamp up
    send_frame(FRAME_LEN, SW_A_CLEAR, -1);      // switch A invalid
    send_frame(FRAME_LEN, SW_B_CLEAR, -1);      // switch B invalid
    send_frame(10, SW_A_CLEAR, -1);             // short and bad switch: length wins
    send_frame(FRAME_LEN + 1, SW_BOTH_SET, -1); // one byte too many
    send_frame(FRAME_LEN - 1, SW_BOTH_SET, -1); // one byte too few
    send_frame(33, SW_BOTH_SET, -1);            // count reaches its ceiling
    send_frame(50, SW_BOTH_SET, -1);            // would alias to 18 if the count wrapped
    send_random_frames(50, 20);
    drain_reports();

    // Widest limits; sender idles often.
    write_limit_reg(REG_MIN, '0);
    write_limit_reg(REG_MAX, CHAN_TOP);
    write_limit_reg(REG_CENTER, '0);
    send_idle_pct = 60;
    send_random_frames(50, 20);
    drain_reports();

    // Crossed limits, centre rewritten, unused slot poked; receiver stalls.
    write_limit_reg(REG_MIN, CHAN_TOP);
    write_limit_reg(REG_MAX, '0);
    write_limit_reg(REG_CENTER, CHAN_TOP);
    write_limit_reg(REG_UNUSED, 11'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    send_random_frames(50, 20);
    drain_reports();

    // Random limits (either order); both sides idle a little.
    write_limit_reg(REG_MIN, 11'($urandom));
    write_limit_reg(REG_MAX, 11'($urandom));
    write_limit_reg(REG_CENTER, 11'($urandom));
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    send_random_frames(50, 20);
    drain_reports();

    // Back-pressure: hold the receiver off for a long stretch while short
    // frames pour in, so the report buffer fills and the input stalls.
    write_limit_reg(REG_MIN, 11'($urandom_range(200, 900)));
    write_limit_reg(REG_MAX, 11'($urandom_range(1100, 1900)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles   <= 300;
    send_random_frames(50, 80);
    drain_reports();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
